/* design/clcd_pkg.sv */
// Shared types, constants and the init command table for the character LCD sequencer.
`default_nettype none

package clcd_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [2:0] INIT_COUNT = 3'd6;
    localparam logic [2:0] INIT_CLEAR = 3'd4;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [9:0]  ENABLE_PULSE_RST = 10'd10;
    localparam logic [9:0]  NIBBLE_HOLD_RST  = 10'd100;
    localparam logic [15:0] POWER_UP_RST     = 16'd3000;
    localparam logic [15:0] CLEAR_WAIT_RST   = 16'd2000;

    typedef enum logic [6:0] {
        PH_POWERUP   = 7'b0000001,
        PH_EN_HIGH1  = 7'b0000010,
        PH_HOLD1     = 7'b0000100,
        PH_EN_HIGH2  = 7'b0001000,
        PH_HOLD2     = 7'b0010000,
        PH_CLEARWAIT = 7'b0100000,
        PH_IDLE      = 7'b1000000
    } phase_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ENABLE_PULSE = 2'd0,
        REG_NIBBLE_HOLD  = 2'd1,
        REG_POWER_UP     = 2'd2,
        REG_CLEAR_WAIT   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [9:0]  enable_pulse;
        logic [9:0]  nibble_hold;
        logic [15:0] power_up;
        logic [15:0] clear_wait;
    } clcd_cfg_t;

    typedef struct packed {
        logic [3:0] bus_nibble;
        logic       select_line;
        logic       enable_line;
        logic       busy_res;
        logic       rejected;
    } clcd_pins_t;

    // Power-on command list: 8-bit twice, 4-bit mode, 2 lines, display on, clear, entry mode.
    function automatic logic [7:0] init_cmd(input logic [2:0] pos);
        logic [7:0] cmd;
        case (pos)
            3'd0:    cmd = 8'h33;
            3'd1:    cmd = 8'h32;
            3'd2:    cmd = 8'h28;
            3'd3:    cmd = 8'h0E;
            3'd4:    cmd = 8'h01;
            3'd5:    cmd = 8'h06;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

/* design/clcd_if.sv */
// Request and result channel interfaces of the character LCD sequencer.
`default_nettype none

interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] byte_value;
    logic       is_data;

    modport source (output valid, operation, byte_value, is_data, input ready);
    modport sink   (input valid, operation, byte_value, is_data, output ready);
endinterface

interface clcd_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] bus_nibble;
    logic       select_line;
    logic       enable_line;
    logic       busy_res;
    logic       rejected;

    modport source (output valid, bus_nibble, select_line, enable_line, busy_res, rejected,
                    input ready);
    modport sink   (input valid, bus_nibble, select_line, enable_line, busy_res, rejected,
                    output ready);
endinterface

`default_nettype wire

/* design/clcd_seq.sv */
// Sequencer state: phase, init position, tick timer and pin registers.
`default_nettype none

module clcd_seq #(
    parameter int TIMER_BITS = clcd_pkg::TIMER_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                operation,
    input  wire logic [7:0]          byte_value,
    input  wire logic                is_data,
    input  wire clcd_pkg::clcd_cfg_t cfg,
    output clcd_pkg::clcd_pins_t     pins
);
    import clcd_pkg::*;

    localparam int CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             pos_reg, pos_next;
    logic [TIMER_BITS-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic [7:0]             pend_reg, pend_next;
    logic [3:0]             nib_reg, nib_next;
    logic                   sel_reg, sel_next;
    logic                   en_reg, en_next;
    logic [15:0]            limit;
    logic                   timer_done;
    logic                   start_init;
    logic [2:0]             start_pos;
    logic                   rej;

    // Limit of the current wait; saturates at the timer's top value.
    always_comb
    begin
        unique case (phase_reg)
            PH_POWERUP:               limit = cfg.power_up;
            PH_EN_HIGH1, PH_EN_HIGH2: limit = 16'(cfg.enable_pulse);
            PH_HOLD1, PH_HOLD2:       limit = 16'(cfg.nibble_hold);
            PH_CLEARWAIT:             limit = cfg.clear_wait;
            default:                  limit = 16'd0;
        endcase
    end

    assign cnt_inc    = cnt_reg + 1'b1;
    assign timer_done = (CMP_BITS'(cnt_inc) >= CMP_BITS'(limit)) || (&cnt_inc);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        nib_next   = nib_reg;
        sel_next   = sel_reg;
        en_next    = en_reg;
        start_init = 1'b0;
        start_pos  = pos_reg;
        rej        = 1'b0;

        if (step)
        begin
            if (operation == OP_TICK)
            begin
                cnt_next = timer_done ? '0 : cnt_inc;
                unique case (phase_reg)
                    PH_POWERUP:
                    begin
                        if (timer_done)
                        begin
                            start_init = 1'b1;
                            start_pos  = 3'd0;
                        end
                    end
                    PH_EN_HIGH1:
                    begin
                        if (timer_done)
                        begin
                            en_next    = 1'b0;
                            phase_next = PH_HOLD1;
                        end
                    end
                    PH_HOLD1:
                    begin
                        if (timer_done)
                        begin
                            nib_next   = pend_reg[3:0];
                            en_next    = 1'b1;
                            phase_next = PH_EN_HIGH2;
                        end
                    end
                    PH_EN_HIGH2:
                    begin
                        if (timer_done)
                        begin
                            en_next    = 1'b0;
                            phase_next = PH_HOLD2;
                        end
                    end
                    PH_HOLD2:
                    begin
                        if (timer_done)
                        begin
                            if (pos_reg >= INIT_COUNT)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (pos_reg == INIT_CLEAR && cfg.clear_wait != 16'd0)
                            begin
                                pos_next   = pos_reg + 3'd1;
                                phase_next = PH_CLEARWAIT;
                            end
                            else
                            begin
                                pos_next   = pos_reg + 3'd1;
                                start_init = 1'b1;
                                start_pos  = pos_reg + 3'd1;
                            end
                        end
                    end
                    PH_CLEARWAIT:
                    begin
                        if (timer_done)
                        begin
                            start_init = 1'b1;
                            start_pos  = pos_reg;
                        end
                    end
                    default:
                    begin
                        cnt_next = cnt_reg;
                    end
                endcase
            end
            else if (phase_reg == PH_IDLE)
            begin
                pend_next  = byte_value;
                sel_next   = is_data;
                nib_next   = byte_value[7:4];
                en_next    = 1'b1;
                cnt_next   = '0;
                phase_next = PH_EN_HIGH1;
            end
            else
            begin
                rej = 1'b1;
            end
        end

        // Next init command, or done once the list is through.
        if (start_init)
        begin
            pos_next = start_pos;
            cnt_next = '0;
            if (start_pos < INIT_COUNT)
            begin
                pend_next  = init_cmd(start_pos);
                sel_next   = 1'b0;
                nib_next   = 4'(init_cmd(start_pos) >> 4);
                en_next    = 1'b1;
                phase_next = PH_EN_HIGH1;
            end
            else
            begin
                pos_next   = INIT_COUNT;
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_POWERUP;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= '0;
            nib_reg   <= '0;
            sel_reg   <= 1'b0;
            en_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            nib_reg   <= nib_next;
            sel_reg   <= sel_next;
            en_reg    <= en_next;
        end
    end

    // Pin levels after this item has been applied.
    assign pins.bus_nibble  = nib_next;
    assign pins.select_line = sel_next;
    assign pins.enable_line = en_next;
    assign pins.busy_res    = (phase_next != PH_IDLE);
    assign pins.rejected    = rej;

endmodule

`default_nettype wire

/* design/char_lcd_nibble_write_sequencer.sv */
// Top level of the character LCD 4-bit write sequencer.
//
// Drives an HD44780-style display over D7..D4, RS and E (R/W tied low).
// Channel "request": one item per microsecond tick (operation = tick) or a
// byte write (operation = write, byte_value, is_data as RS).
// Channel "result": exactly one item per request, the pin levels after that
// request was applied, plus busy_res and rejected (write dropped while busy).
// Config port: cfg_write_en / cfg_index / cfg_data; the user must write
// it only while idle, as the block itself does not enforce this.
// Throughput: one request per clock while results are taken; the input
// register and the result register sit around one step of the sequencer's
// next-state logic. The request side stays ready while a result waits, as
// long as the input register is empty; when the receiver stalls, both stages
// hold and request.ready drops once the input register is full.
// Reset: config returns to its defaults, the sequencer enters the power-up
// wait and then sends 0x33, 0x32, 0x28, 0x0E, 0x01, clear wait, 0x06,
// all paced by ticks; writes before that finish come back rejected.
`default_nettype none

module char_lcd_nibble_write_sequencer #(
    parameter int TIMER_BITS = clcd_pkg::TIMER_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    clcd_req_if.sink                                 request,
    clcd_res_if.source                               result,
    input  wire logic                                cfg_write_en,
    input  wire logic [clcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [clcd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import clcd_pkg::*;

    clcd_cfg_t  cfg_reg;
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       in_data_reg;
    logic       out_valid_reg;
    clcd_pins_t out_pins_reg;
    clcd_pins_t pins;
    logic       advance;
    logic       step;

    // Stages move together unless the result register is full and stalled.
    assign advance       = !out_valid_reg || result.ready;
    assign step          = advance && in_valid_reg;
    assign request.ready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_pulse <= ENABLE_PULSE_RST;
            cfg_reg.nibble_hold  <= NIBBLE_HOLD_RST;
            cfg_reg.power_up     <= POWER_UP_RST;
            cfg_reg.clear_wait   <= CLEAR_WAIT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENABLE_PULSE: cfg_reg.enable_pulse <= cfg_data[9:0];
                REG_NIBBLE_HOLD:  cfg_reg.nibble_hold  <= cfg_data[9:0];
                REG_POWER_UP:     cfg_reg.power_up     <= cfg_data;
                REG_CLEAR_WAIT:   cfg_reg.clear_wait   <= cfg_data;
                default:          cfg_reg.clear_wait   <= cfg_reg.clear_wait;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            in_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            in_op_reg   <= request.operation;
            in_byte_reg <= request.byte_value;
            in_data_reg <= request.is_data;
        end
    end

    clcd_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .operation  (in_op_reg),
        .byte_value (in_byte_reg),
        .is_data    (in_data_reg),
        .cfg        (cfg_reg),
        .pins       (pins)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_pins_reg <= pins;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.bus_nibble  = out_pins_reg.bus_nibble;
    assign result.select_line = out_pins_reg.select_line;
    assign result.enable_line = out_pins_reg.enable_line;
    assign result.busy_res    = out_pins_reg.busy_res;
    assign result.rejected    = out_pins_reg.rejected;

endmodule

`default_nettype wire

/* design/clcd_checker.sv */
// Port-level checks for the character LCD sequencer, bound to the top level.
`default_nettype none

module clcd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [3:0] res_nibble,
    input wire logic       res_select,
    input wire logic       res_enable,
    input wire logic       res_busy,
    input wire logic       res_rejected
);

    // A dropped write only happens while the sequencer is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_rejected) |-> res_busy)
        else $error("rejected result without busy");

    // E is only raised while a nibble is being sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_enable) |-> res_busy)
        else $error("enable high while idle");

    // A stalled result keeps its pin levels.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_nibble)
            && $stable(res_select) && $stable(res_enable) && $stable(res_busy)
            && $stable(res_rejected)))
        else $error("stalled result changed");

endmodule

bind char_lcd_nibble_write_sequencer clcd_checker u_clcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_nibble   (result.bus_nibble),
    .res_select   (result.select_line),
    .res_enable   (result.enable_line),
    .res_busy     (result.busy_res),
    .res_rejected (result.rejected)
);

`default_nettype wire
